// File: sv/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TSQ_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("timer queue check failed");
`define TSQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");
`else
`define TSQ_ASSERT(lbl, cond)
`define TSQ_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: sv/tsq_pkg.sv
// Types and constants of the sorted timer queue.
// No dependencies.
package tsq_pkg;
    localparam int unsigned IdW = 4;
    localparam int unsigned DlW = 64;

    localparam logic [1:0] CMD_ARM    = 2'd0;
    localparam logic [1:0] CMD_DISARM = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_ARMED     = 2'd2;
    localparam logic [1:0] ST_NOT_ARMED = 2'd3;

    localparam logic [DlW-1:0] EMPTY_DL = {1'b0, {(DlW-1){1'b1}}};

    typedef struct packed {
        logic [DlW-1:0] dl;
        logic [IdW-1:0] id;
    } t_entry;
endpackage

// File: sv/tsq_if.sv
// Channel interfaces of the timer queue: command in, result out.
// Depends on nothing.
interface tsq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [3:0]         timer_id;
    logic signed [63:0] deadline;
    logic signed [63:0] now_time;
    modport source (output valid, cmd, timer_id, deadline, now_time, input ready);
    modport sink   (input valid, cmd, timer_id, deadline, now_time, output ready);
endinterface

interface tsq_out_if;
    logic               valid;
    logic               ready;
    logic               was_armed;
    logic               popped_valid;
    logic [3:0]         popped_id;
    logic signed [63:0] earliest_deadline;
    logic [1:0]         status;
    modport source (output valid, was_armed, popped_valid, popped_id, earliest_deadline,
                    status, input ready);
    modport sink   (input valid, was_armed, popped_valid, popped_id, earliest_deadline,
                    status, output ready);
endinterface

// File: sv/tsq_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tsq_ram #(
    parameter int unsigned WIDTH = 68,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/deadline_sorted_timer_queue_unit.sv
// Top level of the sorted timer queue: control, head register, armed map.
// Depends on tsq_pkg, tsq_if.sv, tsq_ram and assert_macros.svh.
//
//  channel | dir | transfer          | payload
//  i_in    | in  | valid & ready     | cmd, timer_id, deadline, now_time
//  o_out   | out | valid & ready     | was_armed, popped_valid, popped_id, ...
//
// Query and refused commands go straight to the result. Arm walks down from the tail,
// moving each later entry up one slot, writes the new entry and reloads the head.
// Disarm and pop walk the queue from the head, pulling later entries down, and reload
// the head unless the queue ends up empty. Each walk step is one RAM read and write.
// Reset clears occupancy, the armed map and the output; entries need none.
// A new command is taken while a result still waits; it finishes only once
// the output register is free.
`include "assert_macros.svh"
module deadline_sorted_timer_queue_unit #(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsq_in_if.sink    i_in,
    tsq_out_if.source o_out
);
    import tsq_pkg::*;

    localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_WR   = 7'b0000100,
        S_NEW  = 7'b0001000,
        S_HRD  = 7'b0010000,
        S_HWR  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_occ, n_occ;
    logic [15:0]       r_armed, n_armed;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_last, n_last;
    logic              r_del, n_del;
    logic              r_found, n_found;
    t_entry            r_new, n_new;
    t_entry            r_head, n_head;
    logic              r_res_armed, n_res_armed;
    logic              r_res_pv, n_res_pv;
    logic [3:0]        r_res_pid, n_res_pid;
    logic [1:0]        r_res_st, n_res_st;
    logic              r_out_valid, n_out_valid;
    logic              r_o_armed, r_o_pv;
    logic [3:0]        r_o_pid;
    logic [DlW-1:0]    r_o_dl;
    logic [1:0]        r_o_st;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_rdata;
    logic              in_xfer, out_free, is_armed, due;

    tsq_ram #(.WIDTH($bits(t_entry)), .DEPTH(TIMER_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign is_armed   = r_armed[i_in.timer_id];
    assign due        = (r_occ != '0) && ($signed(r_head.dl) <= $signed(i_in.now_time));
    assign ram_raddr  = (r_state == S_HRD) ? '0 : r_idx;

    // command sequencer
    always_comb begin
        n_state = r_state; n_occ = r_occ; n_armed = r_armed; n_idx = r_idx;
        n_last = r_last; n_del = r_del; n_found = r_found; n_new = r_new;
        n_head = r_head; n_res_armed = r_res_armed; n_res_pv = r_res_pv;
        n_res_pid = r_res_pid; n_res_st = r_res_st;
        ram_we = 1'b0; ram_waddr = r_idx; ram_wdata = ram_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_armed = is_armed;
                    n_res_pv    = 1'b0;
                    n_res_pid   = '0;
                    n_res_st    = ST_OK;
                    n_state     = S_DONE;
                    n_new.dl    = i_in.deadline;
                    n_new.id    = i_in.timer_id;
                    n_found     = 1'b0;
                    n_last      = AW'(r_occ - CW'(1));
                    case (i_in.cmd)
                        CMD_ARM: begin
                            if (is_armed) begin
                                n_res_st = ST_ARMED;
                            end else if (r_occ >= SLOTS_C) begin
                                n_res_st = ST_FULL;
                            end else begin
                                n_del = 1'b0;
                                n_occ = r_occ + CW'(1);
                                n_armed[i_in.timer_id] = 1'b1;
                                n_idx = AW'(r_occ - CW'(1));
                                n_state = (r_occ == '0) ? S_NEW : S_RD;
                            end
                        end
                        CMD_DISARM: begin
                            if (!is_armed) begin
                                n_res_st = ST_NOT_ARMED;
                            end else begin
                                n_del = 1'b1;
                                n_new.id = i_in.timer_id;
                                n_occ = r_occ - CW'(1);
                                n_armed[i_in.timer_id] = 1'b0;
                                n_idx = '0;
                                n_state = S_RD;
                            end
                        end
                        CMD_POP: begin
                            if (due) begin
                                n_res_pv  = 1'b1;
                                n_res_pid = r_head.id;
                                n_del     = 1'b1;
                                n_new.id  = r_head.id;
                                n_occ     = r_occ - CW'(1);
                                n_armed[r_head.id] = 1'b0;
                                n_idx     = '0;
                                n_state   = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                if (!r_del) begin
                    // insertion walks down from the tail
                    ram_we    = 1'b1;
                    ram_waddr = r_idx + AW'(1);
                    if ($signed(ram_rdata.dl) <= $signed(r_new.dl)) begin
                        ram_wdata = r_new;
                        n_state   = S_HRD;
                    end else if (r_idx == '0) begin
                        n_state = S_NEW;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    // removal: find the id, then pull later entries down
                    ram_we    = r_found;
                    ram_waddr = r_idx - AW'(1);
                    if (ram_rdata.id == r_new.id) begin
                        n_found = 1'b1;
                    end
                    if (r_idx == r_last) begin
                        n_state = S_HRD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_new;
                n_state   = S_HRD;
            end
            S_HRD: n_state = (r_occ == '0) ? S_DONE : S_HWR;
            S_HWR: begin
                n_head  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_last <= n_last; r_del <= n_del; r_found <= n_found;
        r_new <= n_new; r_head <= n_head;
        r_res_armed <= n_res_armed; r_res_pv <= n_res_pv;
        r_res_pid <= n_res_pid; r_res_st <= n_res_st;
        if (r_state == S_DONE && out_free) begin
            r_o_armed <= r_res_armed;
            r_o_pv    <= r_res_pv;
            r_o_pid   <= r_res_pid;
            r_o_dl    <= (r_occ == '0) ? EMPTY_DL : r_head.dl;
            r_o_st    <= r_res_st;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.was_armed         = r_o_armed;
    assign o_out.popped_valid      = r_o_pv;
    assign o_out.popped_id         = r_o_pid;
    assign o_out.earliest_deadline = r_o_dl;
    assign o_out.status            = r_o_st;

    `TSQ_ASSERT(a_occ_matches_map, $countones(r_armed) == 32'(r_occ))
    `TSQ_ASSERT(a_occ_bound, r_occ <= SLOTS_C)
    `TSQ_ASSERT_IMP(a_done_waits, (r_state == S_DONE) && !out_free, ##1 (r_state == S_DONE))
endmodule

// File: verif/tb_deadline_sorted_timer_queue_unit.sv
// Testbench of the sorted timer queue: directed and random commands, checked against
// a behavioural model of the queue held in SystemVerilog. Depends on tsq_pkg and tsq_if.sv.
module tb_deadline_sorted_timer_queue_unit;
    import tsq_pkg::*;

    typedef struct packed {
        logic               was_armed;
        logic               popped_valid;
        logic [3:0]         popped_id;
        logic signed [63:0] earliest_deadline;
        logic [1:0]         status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    tsq_in_if  cmd_ch ();
    tsq_out_if ans_ch ();

    deadline_sorted_timer_queue_unit #(.TIMER_SLOTS(16)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cmd_ch.sink), .o_out(ans_ch.source)
    );

    // Model of the queue contents
    logic signed [63:0] q_dl [16];
    logic [3:0]         q_id [16];
    int                 q_count;
    logic [15:0]        q_armed;
    t_answer            pending_answers [$];
    int                 errors;
    int                 hold_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // Predict one command's answer and update the model
    function automatic t_answer predict_queue(logic [1:0] cmd, logic [3:0] id,
                                              logic signed [63:0] dl, logic signed [63:0] now);
        t_answer a;
        int pos;
        a = '0;
        a.was_armed = q_armed[id];
        a.status = ST_OK;
        if (cmd == CMD_ARM) begin
            if (q_armed[id]) a.status = ST_ARMED;
            else if (q_count >= 16) a.status = ST_FULL;
            else begin
                pos = 0;
                while (pos < q_count && q_dl[pos] <= dl) pos++;
                for (int i = q_count; i > pos; i--) begin
                    q_dl[i] = q_dl[i-1];
                    q_id[i] = q_id[i-1];
                end
                q_dl[pos] = dl;
                q_id[pos] = id;
                q_count++;
                q_armed[id] = 1'b1;
            end
        end else if (cmd == CMD_DISARM) begin
            if (!q_armed[id]) a.status = ST_NOT_ARMED;
            else begin
                pos = 0;
                while (q_id[pos] != id) pos++;
                for (int i = pos; i + 1 < q_count; i++) begin
                    q_dl[i] = q_dl[i+1];
                    q_id[i] = q_id[i+1];
                end
                q_count--;
                q_armed[id] = 1'b0;
            end
        end else if (cmd == CMD_POP) begin
            if (q_count > 0 && q_dl[0] <= now) begin
                a.popped_valid = 1'b1;
                a.popped_id = q_id[0];
                q_armed[q_id[0]] = 1'b0;
                for (int i = 0; i + 1 < q_count; i++) begin
                    q_dl[i] = q_dl[i+1];
                    q_id[i] = q_id[i+1];
                end
                q_count--;
            end
        end
        a.earliest_deadline = (q_count > 0) ? q_dl[0] : EMPTY_DL;
        return a;
    endfunction

    // Send one command; valid stays high into the next command unless a gap is drawn
    task automatic send_cmd(logic [1:0] cmd, logic [3:0] id,
                            logic signed [63:0] dl, logic signed [63:0] now);
        if ($urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= cmd;
        cmd_ch.timer_id <= id;
        cmd_ch.deadline <= dl;
        cmd_ch.now_time <= now;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        pending_answers.push_back(predict_queue(cmd, id, dl, now));
    endtask

    // Receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) ans_ch.ready <= 1'b0;
        else case (hold_mode)
            0: ans_ch.ready <= 1'b1;
            1: ans_ch.ready <= ($urandom_range(0, 3) != 0);
            default: ans_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge i_clk) if ($urandom_range(0, 99) == 0) hold_mode <= $urandom_range(0, 2);

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && ans_ch.valid && ans_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (ans_ch.was_armed !== e.was_armed) begin
                    $error("was_armed exp %0d got %0d", e.was_armed, ans_ch.was_armed);
                    errors++;
                end
                if (ans_ch.popped_valid !== e.popped_valid) begin
                    $error("popped_valid exp %0d got %0d", e.popped_valid, ans_ch.popped_valid);
                    errors++;
                end
                if (ans_ch.popped_id !== e.popped_id) begin
                    $error("popped_id exp %0d got %0d", e.popped_id, ans_ch.popped_id);
                    errors++;
                end
                if (ans_ch.earliest_deadline !== e.earliest_deadline) begin
                    $error("earliest_deadline exp %0h got %0h", e.earliest_deadline,
                           ans_ch.earliest_deadline);
                    errors++;
                end
                if (ans_ch.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, ans_ch.status);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [63:0] rand_time();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return $signed(64'($urandom_range(0, 40))) - 20;
            2: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            default: return $signed(64'($urandom_range(0, 1000)));
        endcase
    endfunction

    // Extremes, every command and the armed and not-armed refusals
    task automatic test_directed();
        send_cmd(CMD_QUERY, 4'd0, 64'sd0, 64'sd0);
        send_cmd(CMD_POP, 4'd0, 64'sd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(CMD_DISARM, 4'd3, 64'sd0, 64'sd0);
        send_cmd(CMD_ARM, 4'd15, 64'h7FFF_FFFF_FFFF_FFFF, 64'sd0);
        send_cmd(CMD_ARM, 4'd0, 64'h8000_0000_0000_0000, 64'sd0);
        send_cmd(CMD_ARM, 4'd15, 64'sd5, 64'sd0);
        send_cmd(CMD_POP, 4'd0, 64'sd0, 64'h8000_0000_0000_0000);
        send_cmd(CMD_POP, 4'd0, 64'sd0, 64'h7FFF_FFFF_FFFE_0000);
        send_cmd(CMD_DISARM, 4'd15, 64'sd0, 64'sd0);
        // fill with ties, then try one more arm (refused as already armed)
        for (int i = 0; i < 16; i++) send_cmd(CMD_ARM, 4'(i), 64'sd7, {$urandom, $urandom});
        send_cmd(CMD_ARM, 4'd4, 64'sd1, 64'sd0);
        send_cmd(CMD_POP, 4'd9, 64'sd0, 64'sd7);
        send_cmd(CMD_ARM, 4'd0, -64'sd1, 64'sd0);
    endtask

    // Random mix in bursts, drained and refilled now and then
    task automatic test_random();
        logic [1:0] c;
        for (int n = 0; n < 1530; n++) begin
            c = $urandom_range(0, 9) < 4 ? CMD_ARM : 2'($urandom_range(1, 3));
            if ((n / 200) % 2 == 1 && c == CMD_ARM) c = CMD_POP;
            send_cmd(c, 4'($urandom_range(0, 15)), rand_time(), rand_time());
        end
    endtask

    initial begin
        int wait_cycles;
        errors = 0;
        hold_mode = 0;
        q_count = 0;
        q_armed = '0;
        i_rst_n = 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.cmd <= CMD_QUERY;
        cmd_ch.timer_id <= '0;
        cmd_ch.deadline <= '0;
        cmd_ch.now_time <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        cmd_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_answers.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $error("results still outstanding: %0d", pending_answers.size());
            errors++;
        end
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/tsq_pkg.sv
sv/tsq_if.sv
sv/tsq_ram.sv
sv/deadline_sorted_timer_queue_unit.sv
verif/tb_deadline_sorted_timer_queue_unit.sv
